// ----- rtl/mbg_pkg.sv -----
`timescale 1ns / 1ps

package mbg_pkg;

    // Opcodes of an input item.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Action codes of a result.
    localparam logic [1:0] ACT_CARVED   = 2'd0;
    localparam logic [1:0] ACT_BACK     = 2'd1;
    localparam logic [1:0] ACT_FINISHED = 2'd2;
    localparam logic [1:0] ACT_DONE     = 2'd3;

    // Carving directions, also the neighbour order.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Wall bits of a cell.
    localparam logic [3:0] WALL_L   = 4'b0001;
    localparam logic [3:0] WALL_R   = 4'b0010;
    localparam logic [3:0] WALL_U   = 4'b0100;
    localparam logic [3:0] WALL_D   = 4'b1000;
    localparam logic [3:0] WALL_ALL = 4'b1111;

    // Configuration registers.
    localparam int         CFG_W    = 6;
    localparam logic       CFG_ROWS = 1'b0;
    localparam logic       CFG_COLS = 1'b1;
    localparam logic [5:0] GRID_RST = 6'd30;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  cell_row_in;
        logic [4:0]  cell_col_in;
        logic [15:0] random_value;
    } t_in;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] cell_row_out;
        logic [4:0] cell_col_out;
        logic [1:0] carve_direction;
        logic [3:0] wall_bits;
    } t_out;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_MARK,
        ST_NB0,
        ST_NB1,
        ST_NB2,
        ST_NB3,
        ST_PICK,
        ST_CV0,
        ST_CV1,
        ST_CV2,
        ST_POP0,
        ST_POP1,
        ST_WRD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       clr;
        logic       mark;
        logic       nb_rd;
        logic [1:0] nb_sel;
        logic       nb_cap;
        logic       pick;
        logic       cv0;
        logic       cv1;
        logic       cv2;
        logic       pop0;
        logic       pop1;
        logic       wrd;
    } t_cmd;

    typedef struct packed {
        logic finished;
        logic clr_last;
        logic has_cand;
        logic stack_empty;
    } t_sts;

endpackage

// ----- rtl/mbg_ctrl.sv -----
`timescale 1ns / 1ps

module mbg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_opcode,
    input  mbg_pkg::t_sts i_sts,
    output mbg_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_done
);

    mbg_pkg::t_state r_state;
    mbg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbg_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mbg_pkg::ST_INIT: begin
                if (i_sts.clr_last) begin
                    n_state = mbg_pkg::ST_IDLE;
                end
            end
            mbg_pkg::ST_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        mbg_pkg::OP_START: n_state = mbg_pkg::ST_CLR;
                        mbg_pkg::OP_STEP: begin
                            n_state = i_sts.finished ? mbg_pkg::ST_WRD : mbg_pkg::ST_NB0;
                        end
                        mbg_pkg::OP_READ: n_state = mbg_pkg::ST_WRD;
                        default:          n_state = mbg_pkg::ST_IDLE;
                    endcase
                end
            end
            mbg_pkg::ST_CLR: begin
                if (i_sts.clr_last) begin
                    n_state = mbg_pkg::ST_MARK;
                end
            end
            mbg_pkg::ST_MARK: n_state = mbg_pkg::ST_WRD;
            mbg_pkg::ST_NB0:  n_state = mbg_pkg::ST_NB1;
            mbg_pkg::ST_NB1:  n_state = mbg_pkg::ST_NB2;
            mbg_pkg::ST_NB2:  n_state = mbg_pkg::ST_NB3;
            mbg_pkg::ST_NB3:  n_state = mbg_pkg::ST_PICK;
            mbg_pkg::ST_PICK: begin
                if (i_sts.has_cand) begin
                    n_state = mbg_pkg::ST_CV0;
                end else if (!i_sts.stack_empty) begin
                    n_state = mbg_pkg::ST_POP0;
                end else begin
                    n_state = mbg_pkg::ST_WRD;
                end
            end
            mbg_pkg::ST_CV0:  n_state = mbg_pkg::ST_CV1;
            mbg_pkg::ST_CV1:  n_state = mbg_pkg::ST_CV2;
            mbg_pkg::ST_CV2:  n_state = mbg_pkg::ST_OUT;
            mbg_pkg::ST_POP0: n_state = mbg_pkg::ST_POP1;
            mbg_pkg::ST_POP1: n_state = mbg_pkg::ST_WRD;
            mbg_pkg::ST_WRD:  n_state = mbg_pkg::ST_OUT;
            mbg_pkg::ST_OUT:  n_state = mbg_pkg::ST_IDLE;
            default:          n_state = mbg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        case (r_state)
            mbg_pkg::ST_INIT: o_cmd.clr = 1'b1;
            mbg_pkg::ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            mbg_pkg::ST_CLR:  o_cmd.clr  = 1'b1;
            mbg_pkg::ST_MARK: o_cmd.mark = 1'b1;
            mbg_pkg::ST_NB0: begin
                o_cmd.nb_rd  = 1'b1;
                o_cmd.nb_sel = mbg_pkg::DIR_UP;
            end
            mbg_pkg::ST_NB1: begin
                o_cmd.nb_rd  = 1'b1;
                o_cmd.nb_sel = mbg_pkg::DIR_DOWN;
                o_cmd.nb_cap = 1'b1;
            end
            mbg_pkg::ST_NB2: begin
                o_cmd.nb_rd  = 1'b1;
                o_cmd.nb_sel = mbg_pkg::DIR_LEFT;
                o_cmd.nb_cap = 1'b1;
            end
            mbg_pkg::ST_NB3: begin
                o_cmd.nb_rd  = 1'b1;
                o_cmd.nb_sel = mbg_pkg::DIR_RIGHT;
                o_cmd.nb_cap = 1'b1;
            end
            mbg_pkg::ST_PICK: o_cmd.pick = 1'b1;
            mbg_pkg::ST_CV0:  o_cmd.cv0  = 1'b1;
            mbg_pkg::ST_CV1:  o_cmd.cv1  = 1'b1;
            mbg_pkg::ST_CV2:  o_cmd.cv2  = 1'b1;
            mbg_pkg::ST_POP0: o_cmd.pop0 = 1'b1;
            mbg_pkg::ST_POP1: o_cmd.pop1 = 1'b1;
            mbg_pkg::ST_WRD:  o_cmd.wrd  = 1'b1;
            mbg_pkg::ST_OUT:  o_done     = 1'b1;
            default:          o_busy     = 1'b1;
        endcase
    end

endmodule

// ----- rtl/mbg_dp.sv -----
`timescale 1ns / 1ps

module mbg_dp #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]  i_cfg_data,
    input  mbg_pkg::t_in               i_item,
    input  mbg_pkg::t_cmd              i_cmd,
    output mbg_pkg::t_sts              o_sts,
    output mbg_pkg::t_out              o_result
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int RUW   = $clog2(MAX_ROWS + 1);
    localparam int CUW   = $clog2(MAX_COLS + 1);
    localparam int AW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col);
        cell_addr = AW'(32'(row) * MAX_COLS + 32'(col));
    endfunction

    // 4 is 1 mod 3, so the base-4 digits can simply be summed.
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 4'(s[1:0]) + 4'(s[4:2]);
        u = 3'(t[1:0]) + 3'(t[3:2]);
        mod3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    function automatic logic [3:0] own_wall(input logic [1:0] dir);
        case (dir)
            mbg_pkg::DIR_UP:   own_wall = mbg_pkg::WALL_U;
            mbg_pkg::DIR_DOWN: own_wall = mbg_pkg::WALL_D;
            mbg_pkg::DIR_LEFT: own_wall = mbg_pkg::WALL_L;
            default:           own_wall = mbg_pkg::WALL_R;
        endcase
    endfunction

    function automatic logic [3:0] other_wall(input logic [1:0] dir);
        case (dir)
            mbg_pkg::DIR_UP:   other_wall = mbg_pkg::WALL_D;
            mbg_pkg::DIR_DOWN: other_wall = mbg_pkg::WALL_U;
            mbg_pkg::DIR_LEFT: other_wall = mbg_pkg::WALL_R;
            default:           other_wall = mbg_pkg::WALL_L;
        endcase
    endfunction

    // Control state
    logic [5:0]    r_grid_rows;
    logic [5:0]    r_grid_cols;
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic [DW-1:0] r_depth;
    logic          r_finished;
    logic [AW-1:0] r_clr_addr;

    // Payload
    logic [1:0]    r_rnd_lo;
    logic [1:0]    r_m3;
    logic [2:0]    r_nb_vis;
    logic [1:0]    r_dir;
    logic [3:0]    r_mask;
    logic [1:0]    r_action;
    logic [RW-1:0] r_rep_row;
    logic [CW-1:0] r_rep_col;
    logic          r_vis_q;
    logic [3:0]    r_wall_q;
    logic [RW+CW-1:0] r_stk_q;

    logic             mem_vis  [CELLS];
    logic [3:0]       mem_wall [CELLS];
    logic [RW+CW-1:0] mem_stk  [CELLS];

    logic [RUW-1:0] rows_used;
    logic [CUW-1:0] cols_used;
    logic [RUW-1:0] cr_x;
    logic [CUW-1:0] cc_x;
    logic           cur_r_ok;
    logic           cur_c_ok;
    logic [3:0]     nb_ok;
    logic [RW-1:0]  nb_row [4];
    logic [CW-1:0]  nb_col [4];
    logic [RW-1:0]  in_row;
    logic [CW-1:0]  in_col;
    logic [AW-1:0]  cur_addr;
    logic [AW-1:0]  rep_addr;
    logic [AW-1:0]  vis_ra;
    logic [3:0]     cand;
    logic [2:0]     n_cand;
    logic [1:0]     k_sel;
    logic [1:0]     pick_dir;
    logic           push_ok;
    logic [DW-1:0]  depth_m1;

    logic           vis_we;
    logic [AW-1:0]  vis_wa;
    logic           vis_wd;
    logic           wall_we;
    logic [AW-1:0]  wall_wa;
    logic [3:0]     wall_wd;
    logic           wall_re;
    logic [AW-1:0]  wall_ra;

    always_comb begin
        if (r_grid_rows == 6'd0) begin
            rows_used = RUW'(1);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            rows_used = RUW'(MAX_ROWS);
        end else begin
            rows_used = RUW'(r_grid_rows);
        end
        if (r_grid_cols == 6'd0) begin
            cols_used = CUW'(1);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            cols_used = CUW'(MAX_COLS);
        end else begin
            cols_used = CUW'(r_grid_cols);
        end
    end

    // Start and read cells are clamped into the grid.
    always_comb begin
        if (32'(i_item.cell_row_in) >= 32'(rows_used)) begin
            in_row = RW'(rows_used - RUW'(1));
        end else begin
            in_row = RW'(i_item.cell_row_in);
        end
        if (32'(i_item.cell_col_in) >= 32'(cols_used)) begin
            in_col = CW'(cols_used - CUW'(1));
        end else begin
            in_col = CW'(i_item.cell_col_in);
        end
    end

    // The current cell itself may lie outside a shrunken grid.
    assign cr_x     = RUW'(r_cur_row);
    assign cc_x     = CUW'(r_cur_col);
    assign cur_r_ok = cr_x < rows_used;
    assign cur_c_ok = cc_x < cols_used;

    always_comb begin
        nb_ok[mbg_pkg::DIR_UP]    = ((cr_x + RUW'(1)) < rows_used) && cur_c_ok;
        nb_ok[mbg_pkg::DIR_DOWN]  = (r_cur_row != '0) && ((cr_x - RUW'(1)) < rows_used)
                                    && cur_c_ok;
        nb_ok[mbg_pkg::DIR_LEFT]  = (r_cur_col != '0) && cur_r_ok
                                    && ((cc_x - CUW'(1)) < cols_used);
        nb_ok[mbg_pkg::DIR_RIGHT] = cur_r_ok && ((cc_x + CUW'(1)) < cols_used);

        nb_row[mbg_pkg::DIR_UP]    = r_cur_row + RW'(1);
        nb_col[mbg_pkg::DIR_UP]    = r_cur_col;
        nb_row[mbg_pkg::DIR_DOWN]  = r_cur_row - RW'(1);
        nb_col[mbg_pkg::DIR_DOWN]  = r_cur_col;
        nb_row[mbg_pkg::DIR_LEFT]  = r_cur_row;
        nb_col[mbg_pkg::DIR_LEFT]  = r_cur_col - CW'(1);
        nb_row[mbg_pkg::DIR_RIGHT] = r_cur_row;
        nb_col[mbg_pkg::DIR_RIGHT] = r_cur_col + CW'(1);
    end

    assign cur_addr = cell_addr(r_cur_row, r_cur_col);
    assign rep_addr = cell_addr(r_rep_row, r_rep_col);
    assign vis_ra   = nb_ok[i_cmd.nb_sel] ? cell_addr(nb_row[i_cmd.nb_sel], nb_col[i_cmd.nb_sel])
                                          : cur_addr;

    // The right neighbour's bit is still in the read register during the pick.
    assign cand   = nb_ok & ~{r_vis_q, r_nb_vis};
    assign n_cand = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);

    always_comb begin
        case (n_cand)
            3'd2:    k_sel = {1'b0, r_rnd_lo[0]};
            3'd3:    k_sel = r_m3;
            3'd4:    k_sel = r_rnd_lo;
            default: k_sel = 2'd0;
        endcase
    end

    always_comb begin
        logic [1:0] cnt;
        logic       found;
        cnt      = 2'd0;
        found    = 1'b0;
        pick_dir = mbg_pkg::DIR_UP;
        for (int i = 0; i < 4; i++) begin
            if (cand[i]) begin
                if (!found && cnt == k_sel) begin
                    pick_dir = 2'(i);
                    found    = 1'b1;
                end
                cnt = cnt + 2'd1;
            end
        end
    end

    assign push_ok  = r_depth < DW'(CELLS);
    assign depth_m1 = r_depth - DW'(1);

    // Memory port muxes
    always_comb begin
        vis_we = 1'b0;
        vis_wa = rep_addr;
        vis_wd = 1'b1;
        if (i_cmd.clr) begin
            vis_we = 1'b1;
            vis_wa = r_clr_addr;
            vis_wd = 1'b0;
        end else if (i_cmd.mark || i_cmd.cv0) begin
            vis_we = 1'b1;
        end
    end

    always_comb begin
        wall_we = 1'b0;
        wall_wa = rep_addr;
        wall_wd = mbg_pkg::WALL_ALL;
        if (i_cmd.clr) begin
            wall_we = 1'b1;
            wall_wa = r_clr_addr;
        end else if (i_cmd.cv1) begin
            wall_we = 1'b1;
            wall_wa = cur_addr;
            wall_wd = r_wall_q & ~own_wall(r_dir);
        end else if (i_cmd.cv2) begin
            wall_we = 1'b1;
            wall_wd = r_wall_q & ~r_mask;
        end
        wall_re = i_cmd.cv0 || i_cmd.cv1 || i_cmd.wrd;
        wall_ra = i_cmd.cv0 ? cur_addr : rep_addr;
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            mem_vis[vis_wa] <= vis_wd;
        end
        if (i_cmd.nb_rd) begin
            r_vis_q <= mem_vis[vis_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wall_we) begin
            mem_wall[wall_wa] <= wall_wd;
        end
        if (wall_re) begin
            r_wall_q <= mem_wall[wall_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cv0 && push_ok) begin
            mem_stk[r_depth[AW-1:0]] <= {r_cur_row, r_cur_col};
        end
        if (i_cmd.pop0) begin
            r_stk_q <= mem_stk[depth_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= mbg_pkg::GRID_RST;
            r_grid_cols <= mbg_pkg::GRID_RST;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_depth     <= '0;
            r_finished  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mbg_pkg::CFG_ROWS) begin
                    r_grid_rows <= i_cfg_data;
                end else begin
                    r_grid_cols <= i_cfg_data;
                end
            end
            if (i_cmd.clr) begin
                r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + AW'(1);
            end
            if (i_cmd.mark) begin
                r_cur_row  <= r_rep_row;
                r_cur_col  <= r_rep_col;
                r_depth    <= '0;
                r_finished <= 1'b0;
            end
            if (i_cmd.pick && !o_sts.has_cand && o_sts.stack_empty) begin
                r_finished <= 1'b1;
            end
            if (i_cmd.cv0 && push_ok) begin
                r_depth <= r_depth + DW'(1);
            end
            if (i_cmd.cv1) begin
                r_cur_row <= r_rep_row;
                r_cur_col <= r_rep_col;
            end
            if (i_cmd.pop0) begin
                r_depth <= depth_m1;
            end
            if (i_cmd.pop1) begin
                r_cur_row <= r_stk_q[RW+CW-1:CW];
                r_cur_col <= r_stk_q[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rnd_lo <= i_item.random_value[1:0];
            r_m3     <= mod3(i_item.random_value);
            r_dir    <= mbg_pkg::DIR_UP;
            r_mask   <= '0;
            if (i_item.opcode == mbg_pkg::OP_STEP) begin
                r_action  <= mbg_pkg::ACT_FINISHED;
                r_rep_row <= r_cur_row;
                r_rep_col <= r_cur_col;
            end else begin
                r_action  <= mbg_pkg::ACT_DONE;
                r_rep_row <= in_row;
                r_rep_col <= in_col;
            end
        end
        if (i_cmd.nb_cap) begin
            r_nb_vis <= {r_vis_q, r_nb_vis[2:1]};
        end
        if (i_cmd.pick) begin
            if (o_sts.has_cand) begin
                r_dir     <= pick_dir;
                r_mask    <= other_wall(pick_dir);
                r_action  <= mbg_pkg::ACT_CARVED;
                r_rep_row <= nb_row[pick_dir];
                r_rep_col <= nb_col[pick_dir];
            end else if (o_sts.stack_empty) begin
                r_action  <= mbg_pkg::ACT_FINISHED;
                r_rep_row <= r_cur_row;
                r_rep_col <= r_cur_col;
            end else begin
                r_action <= mbg_pkg::ACT_BACK;
            end
        end
        if (i_cmd.pop1) begin
            r_rep_row <= r_stk_q[RW+CW-1:CW];
            r_rep_col <= r_stk_q[CW-1:0];
        end
    end

    assign o_sts.finished    = r_finished;
    assign o_sts.clr_last    = r_clr_addr == AW'(CELLS - 1);
    assign o_sts.has_cand    = |cand;
    assign o_sts.stack_empty = r_depth == '0;

    // A carved cell reports its walls after the shared wall is removed.
    assign o_result.action          = r_action;
    assign o_result.cell_row_out    = 5'(r_rep_row);
    assign o_result.cell_col_out    = 5'(r_rep_col);
    assign o_result.carve_direction = r_dir;
    assign o_result.wall_bits       = r_wall_q & ~r_mask;

endmodule

// ----- rtl/maze_backtracker_generator.sv -----
`timescale 1ns / 1ps
// Start: a clearing pass over every cell, then the start cell is marked and its walls are read.
// Read, or step once finished: the cell's walls are read, then the result follows.
// Step: neighbour reads and a pick, then a carve, a pop, or on the finishing step a wall read.
// One item at a time, bounded by one read and one write port per memory; results cannot stall.
// Synchronous reset runs a clearing pass over all MAX_ROWS*MAX_COLS cells with busy high.
module maze_backtracker_generator #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  mbg_pkg::t_in              i_item,
    output logic                      o_done,
    output mbg_pkg::t_out             o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0] i_cfg_data
);

    mbg_pkg::t_cmd cmd;
    mbg_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    mbg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_item.opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    mbg_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_result)
    );

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a busy item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.opcode != mbg_pkg::OP_NONE)) |=> busy)
        else $error("transfer with a result did not make the block busy");

    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.action != mbg_pkg::ACT_CARVED))
        |-> (o_result.carve_direction == mbg_pkg::DIR_UP))
        else $error("direction set on a result that did not carve");

    a_carve_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.action == mbg_pkg::ACT_CARVED))
        |-> (((o_result.carve_direction == mbg_pkg::DIR_UP) && !o_result.wall_bits[3])
          || ((o_result.carve_direction == mbg_pkg::DIR_DOWN) && !o_result.wall_bits[2])
          || ((o_result.carve_direction == mbg_pkg::DIR_LEFT) && !o_result.wall_bits[1])
          || ((o_result.carve_direction == mbg_pkg::DIR_RIGHT) && !o_result.wall_bits[0])))
        else $error("carved cell still has the wall toward its parent");

endmodule
